// ===== sv/v4n_pkg.sv =====
`default_nettype none
package v4n_pkg;
	// number of vector components
	localparam int LANES = 4;
	// unit components: signed Q2.30
	localparam int UNIT_FRAC = 30;
	localparam int UNIT_WIDTH = 32;
	// quotient bits of round(|c| * 2^UNIT_FRAC / len), at most 2^UNIT_FRAC
	localparam int QUO_BITS = UNIT_FRAC + 1;
	// plus one in Q2.30
	localparam logic signed [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(64'd1 << UNIT_FRAC);
endpackage
`default_nettype wire

// ===== sv/vec4_normalize.sv =====
`default_nettype none
// Four-component vector normalizer. Each input item is a vector of four signed
// fixed-point components (comp_x..comp_w). Each output item carries the vector
// scaled to unit length (unit_x..unit_w, signed Q2.30), its rounded Euclidean
// length (magnitude) and was_zero, set when the length is zero and all units
// are zero. Both channels use valid and stall; an item moves on a rising edge
// with valid high and stall low.
// The pipeline registers absolute values, squares, pair sums and the sum of
// squares, then takes one root bit per square-root stage, rounds the root
// and sets up the dividend and divisor, takes one quotient bit per divider
// stage and ends in the output register. One item can enter every cycle
// while in_stall is low.
// The whole pipeline moves as one: while the output register holds an item
// that the receiver stalls, in_stall is high and every stage holds; idle
// stages still advance whenever the output is free. Reset clears all valid
// bits, so no item is in flight afterwards; data registers are not reset.
module vec4_normalize #(
	parameter int COMPONENT_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [COMPONENT_WIDTH-1:0]     comp_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0]     comp_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0]     comp_z,
	input  wire logic signed [COMPONENT_WIDTH-1:0]     comp_w,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [v4n_pkg::UNIT_WIDTH-1:0]      unit_x,
	output logic signed [v4n_pkg::UNIT_WIDTH-1:0]      unit_y,
	output logic signed [v4n_pkg::UNIT_WIDTH-1:0]      unit_z,
	output logic signed [v4n_pkg::UNIT_WIDTH-1:0]      unit_w,
	output logic [COMPONENT_WIDTH:0]                   magnitude,
	output logic                                       was_zero
);
	import v4n_pkg::*;

	localparam int W   = COMPONENT_WIDTH;
	localparam int SQW = 2 * W;
	localparam int SW  = 2 * W + 2;
	localparam int RB  = W + 1;
	localparam int RW  = W + 3;
	localparam int QB  = QUO_BITS;
	localparam int NW  = W + QB + 1;
	localparam int DW  = W + 2;

	logic advance;
	logic [W-1:0] comp_in [LANES];

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [W-1:0]        mag_s1 [LANES];
	logic [W-1:0]        mag_s2 [LANES];
	logic [W-1:0]        mag_s3 [LANES];
	logic [W-1:0]        mag_s4 [LANES];
	logic [LANES-1:0]    neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SQW-1:0]      sq_s2 [LANES];
	logic [SQW:0]        pair_s3 [2];
	logic [SW-1:0]       sum_s4;

	// square-root pipeline, one root bit per stage
	logic                valid_sk [RB];
	logic [SW-1:0]       rad_sk [RB];
	logic [RW-1:0]       rem_sk [RB];
	logic [RB-1:0]       root_sk [RB];
	logic [W-1:0]        mag_sk [RB][LANES];
	logic [LANES-1:0]    neg_sk [RB];
	logic                valid_in_sk [RB];
	logic [SW-1:0]       rad_in_sk [RB];
	logic [RW-1:0]       rem_in_sk [RB];
	logic [RB-1:0]       root_in_sk [RB];
	logic [W-1:0]        mag_in_sk [RB][LANES];
	logic [LANES-1:0]    neg_in_sk [RB];

	logic                valid_s5, valid_s6;
	logic [RB-1:0]       len_s5, len_s6;
	logic [W-1:0]        mag_s5 [LANES];
	logic [LANES-1:0]    neg_s5, neg_s6;
	logic [NW-1:0]       num_s6 [LANES];
	logic [DW-1:0]       den_s6;
	logic                zero_s6;

	// divider pipeline, one quotient bit per stage
	logic                valid_sd [QB];
	logic [DW-1:0]       rem_sd [QB][LANES];
	logic [QB-1:0]       low_sd [QB][LANES];
	logic [QB-1:0]       quo_sd [QB][LANES];
	logic [DW-1:0]       den_sd [QB];
	logic [RB-1:0]       len_sd [QB];
	logic [LANES-1:0]    neg_sd [QB];
	logic                zero_sd [QB];
	logic                valid_in_sd [QB];
	logic [DW-1:0]       rem_in_sd [QB][LANES];
	logic [QB-1:0]       low_in_sd [QB][LANES];
	logic [QB-1:0]       quo_in_sd [QB][LANES];
	logic [DW-1:0]       den_in_sd [QB];
	logic [RB-1:0]       len_in_sd [QB];
	logic [LANES-1:0]    neg_in_sd [QB];
	logic                zero_in_sd [QB];

	logic                       out_valid_q;
	logic [UNIT_WIDTH-1:0]      unit_q [LANES];
	logic [RB-1:0]              mag_q;
	logic                       zero_q;

	// global hold while the receiver stalls a waiting item
	assign advance = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	assign comp_in[0] = comp_x;
	assign comp_in[1] = comp_y;
	assign comp_in[2] = comp_z;
	assign comp_in[3] = comp_w;

	// valid bits of the front, rounding and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_sk[RB-1];
			valid_s6 <= valid_s5;
			out_valid_q <= valid_sd[QB-1];
		end
	end

	// absolute values, squares, sum of squares
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < LANES; i++) begin
				neg_s1[i] <= comp_in[i][W-1];
				mag_s1[i] <= comp_in[i][W-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
				sq_s2[i] <= SQW'(mag_s1[i]) * SQW'(mag_s1[i]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pair_s3[0] <= (SQW+1)'(sq_s2[0]) + (SQW+1)'(sq_s2[1]);
			pair_s3[1] <= (SQW+1)'(sq_s2[2]) + (SQW+1)'(sq_s2[3]);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sum_s4 <= SW'(pair_s3[0]) + SW'(pair_s3[1]);
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// square-root stage inputs
	always_comb begin
		valid_in_sk[0] = valid_s4;
		rad_in_sk[0] = sum_s4;
		rem_in_sk[0] = '0;
		root_in_sk[0] = '0;
		mag_in_sk[0] = mag_s4;
		neg_in_sk[0] = neg_s4;
		for (int k = 1; k < RB; k++) begin
			valid_in_sk[k] = valid_sk[k-1];
			rad_in_sk[k] = rad_sk[k-1];
			rem_in_sk[k] = rem_sk[k-1];
			root_in_sk[k] = root_sk[k-1];
			mag_in_sk[k] = mag_sk[k-1];
			neg_in_sk[k] = neg_sk[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RB; k++)
				valid_sk[k] <= 1'b0;
		end else if (advance) begin
			valid_sk <= valid_in_sk;
		end
	end

	// one restoring root step per stage: bring down two radicand bits
	always_ff @(posedge clk) begin
		logic [RW-1:0] acc;
		logic [RW-1:0] trial;
		if (advance) begin
			for (int k = 0; k < RB; k++) begin
				acc = {rem_in_sk[k][RW-3:0], rad_in_sk[k][SW-1 -: 2]};
				trial = {root_in_sk[k], 2'b01};
				rad_sk[k] <= rad_in_sk[k] << 2;
				if (acc >= trial) begin
					rem_sk[k] <= acc - trial;
					root_sk[k] <= {root_in_sk[k][RB-2:0], 1'b1};
				end else begin
					rem_sk[k] <= acc;
					root_sk[k] <= {root_in_sk[k][RB-2:0], 1'b0};
				end
				mag_sk[k] <= mag_in_sk[k];
				neg_sk[k] <= neg_in_sk[k];
			end
		end
	end

	// round the root, then set up dividend and divisor
	always_ff @(posedge clk) begin
		if (advance) begin
			len_s5 <= root_sk[RB-1]
				+ RB'(rem_sk[RB-1] > RW'(root_sk[RB-1]));
			mag_s5 <= mag_sk[RB-1];
			neg_s5 <= neg_sk[RB-1];
			for (int i = 0; i < LANES; i++)
				num_s6[i] <= (NW'(mag_s5[i]) << QB) + NW'(len_s5);
			den_s6 <= {len_s5, 1'b0};
			len_s6 <= len_s5;
			neg_s6 <= neg_s5;
			zero_s6 <= (len_s5 == '0);
		end
	end

	// divider stage inputs
	always_comb begin
		valid_in_sd[0] = valid_s6;
		den_in_sd[0] = den_s6;
		len_in_sd[0] = len_s6;
		neg_in_sd[0] = neg_s6;
		zero_in_sd[0] = zero_s6;
		for (int i = 0; i < LANES; i++) begin
			rem_in_sd[0][i] = DW'(num_s6[i][NW-1:QB]);
			low_in_sd[0][i] = num_s6[i][QB-1:0];
			quo_in_sd[0][i] = '0;
		end
		for (int j = 1; j < QB; j++) begin
			valid_in_sd[j] = valid_sd[j-1];
			den_in_sd[j] = den_sd[j-1];
			len_in_sd[j] = len_sd[j-1];
			neg_in_sd[j] = neg_sd[j-1];
			zero_in_sd[j] = zero_sd[j-1];
			rem_in_sd[j] = rem_sd[j-1];
			low_in_sd[j] = low_sd[j-1];
			quo_in_sd[j] = quo_sd[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QB; j++)
				valid_sd[j] <= 1'b0;
		end else if (advance) begin
			valid_sd <= valid_in_sd;
		end
	end

	// one restoring division step per stage for each lane
	always_ff @(posedge clk) begin
		logic [DW:0] part;
		if (advance) begin
			for (int j = 0; j < QB; j++) begin
				for (int i = 0; i < LANES; i++) begin
					part = {rem_in_sd[j][i], low_in_sd[j][i][QB-1]};
					low_sd[j][i] <= low_in_sd[j][i] << 1;
					if (part >= {1'b0, den_in_sd[j]}) begin
						rem_sd[j][i] <= DW'(part - {1'b0, den_in_sd[j]});
						quo_sd[j][i] <= {quo_in_sd[j][i][QB-2:0], 1'b1};
					end else begin
						rem_sd[j][i] <= DW'(part);
						quo_sd[j][i] <= {quo_in_sd[j][i][QB-2:0], 1'b0};
					end
				end
				den_sd[j] <= den_in_sd[j];
				len_sd[j] <= len_in_sd[j];
				neg_sd[j] <= neg_in_sd[j];
				zero_sd[j] <= zero_in_sd[j];
			end
		end
	end

	// output register: apply signs, force zero vector
	always_ff @(posedge clk) begin
		logic [UNIT_WIDTH-1:0] q;
		if (advance) begin
			for (int i = 0; i < LANES; i++) begin
				q = UNIT_WIDTH'(quo_sd[QB-1][i]);
				if (zero_sd[QB-1])
					unit_q[i] <= '0;
				else if (neg_sd[QB-1][i])
					unit_q[i] <= ~q + 1'b1;
				else
					unit_q[i] <= q;
			end
			mag_q <= len_sd[QB-1];
			zero_q <= zero_sd[QB-1];
		end
	end

	assign out_valid = out_valid_q;
	assign unit_x = unit_q[0];
	assign unit_y = unit_q[1];
	assign unit_z = unit_q[2];
	assign unit_w = unit_q[3];
	assign magnitude = mag_q;
	assign was_zero = zero_q;

`ifndef NO_ASSERTIONS
	a_stall_only_on_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output item");

	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_zero) |-> (magnitude == '0 && unit_x == '0 && unit_y == '0
			&& unit_z == '0 && unit_w == '0))
		else $error("zero vector item with nonzero fields");

	a_nonzero_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !was_zero) |-> (magnitude != '0))
		else $error("zero length without was_zero");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (unit_x <= UNIT_ONE && unit_x >= -UNIT_ONE
			&& unit_y <= UNIT_ONE && unit_y >= -UNIT_ONE
			&& unit_z <= UNIT_ONE && unit_z >= -UNIT_ONE
			&& unit_w <= UNIT_ONE && unit_w >= -UNIT_ONE))
		else $error("unit component beyond one");
`endif
endmodule
`default_nettype wire

// ===== sim/vec4_normalize_checker.sv =====
`timescale 1ns / 1ps
module vec4_normalize_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [31:0] comp_x,
	input  wire logic signed [31:0] comp_y,
	input  wire logic signed [31:0] comp_z,
	input  wire logic signed [31:0] comp_w,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [31:0] unit_x,
	input  wire logic signed [31:0] unit_y,
	input  wire logic signed [31:0] unit_z,
	input  wire logic signed [31:0] unit_w,
	input  wire logic [32:0]        magnitude,
	input  wire logic               was_zero,
	output int                      fail_count,
	output int                      pending
);
	typedef struct {
		logic signed [31:0] ux, uy, uz, uw;
		logic [32:0]        len;
		logic               zero;
	} norm_t;

	norm_t unit_queue[$];

	// absolute value of a component, most negative handled exactly
	function automatic logic [31:0] abs_comp(logic signed [31:0] c);
		return c[31] ? 32'(-{c[31], c}) : 32'(c);
	endfunction

	// rounded quotient |c| * 2^30 / len, ties away from zero, sign restored
	function automatic logic signed [31:0] scale_comp(logic signed [31:0] c, logic [32:0] len);
		logic [127:0] num;
		logic [127:0] q;
		num = ({96'd0, abs_comp(c)} << 31) + {95'd0, len};
		q = num / ({95'd0, len} << 1);
		return c[31] ? -q[31:0] : q[31:0];
	endfunction

	function automatic norm_t normalize(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] w);
		norm_t r;
		logic [127:0] sq_sum;
		logic [127:0] root;
		logic [127:0] lo;
		logic [127:0] hi;
		logic [127:0] mid;
		sq_sum = {96'd0, abs_comp(x)} * {96'd0, abs_comp(x)}
			+ {96'd0, abs_comp(y)} * {96'd0, abs_comp(y)}
			+ {96'd0, abs_comp(z)} * {96'd0, abs_comp(z)}
			+ {96'd0, abs_comp(w)} * {96'd0, abs_comp(w)};
		// floor root by bisection
		lo = '0;
		hi = 128'd1 << 33;
		while (hi - lo > 128'd1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= sq_sum)
				lo = mid;
			else
				hi = mid;
		end
		root = lo;
		if (sq_sum - root * root > root)
			root = root + 128'd1;
		r.len = root[32:0];
		r.zero = (root == '0);
		if (r.zero) begin
			r.ux = '0; r.uy = '0; r.uz = '0; r.uw = '0;
		end else begin
			r.ux = scale_comp(x, r.len);
			r.uy = scale_comp(y, r.len);
			r.uz = scale_comp(z, r.len);
			r.uw = scale_comp(w, r.len);
		end
		return r;
	endfunction

	assign pending = unit_queue.size();

	// predict on accepted input, compare on accepted output
	always @(posedge clk or negedge arst_n) begin
		norm_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			unit_queue.delete();
		end else begin
			if (in_valid && !in_stall)
				unit_queue.push_back(normalize(comp_x, comp_y, comp_z, comp_w));
			if (out_valid && !out_stall) begin
				if (unit_queue.size() == 0) begin
					$error("unexpected item: no vector pending");
					errs++;
				end else begin
					e = unit_queue.pop_front();
					if (unit_x !== e.ux) begin
						$error("unit_x expected %0d actual %0d", e.ux, unit_x);
						errs++;
					end
					if (unit_y !== e.uy) begin
						$error("unit_y expected %0d actual %0d", e.uy, unit_y);
						errs++;
					end
					if (unit_z !== e.uz) begin
						$error("unit_z expected %0d actual %0d", e.uz, unit_z);
						errs++;
					end
					if (unit_w !== e.uw) begin
						$error("unit_w expected %0d actual %0d", e.uw, unit_w);
						errs++;
					end
					if (magnitude !== e.len) begin
						$error("magnitude expected %0d actual %0d", e.len, magnitude);
						errs++;
					end
					if (was_zero !== e.zero) begin
						$error("was_zero expected %0d actual %0d", e.zero, was_zero);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== sim/tb_vec4_normalize.sv =====
`timescale 1ns / 1ps
module tb_vec4_normalize;
	localparam int RANDOM_ITEMS = 1030;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] comp_x, comp_y, comp_z, comp_w;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] unit_x, unit_y, unit_z, unit_w;
	logic [32:0]        magnitude;
	logic               was_zero;
	int                 fail_count;
	int                 pending;
	int                 cycle_count = 0;
	logic               hold_long;
	logic               calm;

	vec4_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
		.magnitude(magnitude), .was_zero(was_zero)
	);

	vec4_normalize_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
		.magnitude(magnitude), .was_zero(was_zero),
		.fail_count(fail_count), .pending(pending)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vec4_normalize: mismatch");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, calm stretch
	initial begin
		out_stall = 1'b0;
		hold_long = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (cycle_count == 300)
				hold_long = 1'b1;
			if (cycle_count == 500)
				hold_long = 1'b0;
			out_stall <= hold_long || (!calm && $urandom_range(99) < 23);
		end
	end

	// one vector offered, held until accepted; returns at the next falling edge
	task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random component: full range, small values, extremes
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			1: return 32'($signed($urandom_range(8)) - 4);
			2: return 32'($signed($urandom_range(131072)) - 65536);
			3: return $urandom_range(1) ? 32'd0 : 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		comp_x = '0; comp_y = '0; comp_z = '0; comp_w = '0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: zero vector, extremes, single axes, ties
		send_vec(32'd0, 32'd0, 32'd0, 32'd0);
		send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vec(32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_vec(32'd0, 32'h7fff_ffff, 32'd0, 32'd0);
		send_vec(32'd0, 32'd0, 32'h0001_0000, 32'd0);
		send_vec(32'd0, 32'd0, 32'd0, 32'hffff_0000);
		send_vec(32'd1, 32'd0, 32'd0, 32'd0);
		send_vec(32'hffff_ffff, 32'd0, 32'd0, 32'd0);
		send_vec(32'd1, 32'd1, 32'd1, 32'd1);
		send_vec(32'd1, 32'd1, 32'd0, 32'd0);
		send_vec(32'd3, 32'd4, 32'd0, 32'd0);
		send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa);
		send_vec(32'd2, 32'd1, 32'd1, 32'd1);
		send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_vec(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 32'hffff_0000);
		// random
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 400 && i < 550);
			send_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("vec4_normalize: match");
		else
			$display("vec4_normalize: mismatch");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/v4n_pkg.sv
sv/vec4_normalize.sv
sim/vec4_normalize_checker.sv
sim/tb_vec4_normalize.sv
